### rtl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared widths, codes and pipeline bus types of the redshift-space map.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int QW            = 35;   // quotient bits kept by the divider
  localparam int DEN_W         = 97;   // |D|^2 * H
  localparam int DIV_W         = DEN_W + QW + 1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CENTER = 2'd1;
  localparam logic [1:0] ST_SAT    = 2'd2;

  localparam logic [1:0] REG_HUBBLE = 2'd0;
  localparam logic [1:0] REG_CX     = 2'd1;
  localparam logic [1:0] REG_CY     = 2'd2;
  localparam logic [1:0] REG_CZ     = 2'd3;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0]       dneg;
    logic             svneg;
    logic             zero;
  } side_t;

  typedef struct packed {
    logic                      valid;
    side_t                     side;
    logic [2:0][DIV_W-1:0]     rem;
    logic [DIV_W-1:0]          den;
    logic [2:0][QW-1:0]        quo;
    logic [2:0]                ovf;
  } div_bus_t;

endpackage

### rtl/rsp_front.sv
// ----------------------------------------------------------------------------
// rsp_front
// Six-stage front end: offsets, squares and dot products, sums, and the
// numerator and denominator of the radial offset.
// ----------------------------------------------------------------------------
module rsp_front import rsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_take,
  input  logic [2:0][31:0]        pos,
  input  logic [2:0][31:0]        vel,
  input  logic [30:0]             hubble,
  input  logic [2:0][31:0]        center,
  output div_bus_t                bus
);

  // stage 1
  logic             v1_r;
  logic [2:0][31:0] pos1_r, dm1_r, vm1_r;
  logic [2:0]       dneg1_r, vneg1_r;
  // stage 2
  logic             v2_r;
  logic [2:0][31:0] pos2_r, dm2_r;
  logic [2:0]       dneg2_r, pn2_r;
  logic [2:0][63:0] sq2_r, pr2_r;
  // stage 3
  logic             v3_r;
  logic [2:0][31:0] pos3_r, dm3_r;
  logic [2:0]       dneg3_r;
  logic [65:0]      s2_3_r;
  logic [66:0]      sv3_r;
  // stage 4
  logic             v4_r;
  logic [2:0][31:0] pos4_r, dm4_r;
  logic [2:0]       dneg4_r;
  logic             svneg4_r, zero4_r;
  logic [65:0]      svm4_r;
  logic [62:0]      dlo4_r;
  logic [64:0]      dhi4_r;
  // stage 5
  logic             v5_r;
  logic [2:0][31:0] pos5_r;
  logic [2:0]       dneg5_r;
  logic             svneg5_r, zero5_r;
  logic [DEN_W-1:0] den5_r;
  logic [2:0][63:0] nlo5_r;
  logic [2:0][65:0] nhi5_r;
  // stage 6
  div_bus_t         bus_r;

  logic [2:0][32:0] dd, vv;
  logic [65:0]      s2_sum;
  logic [66:0]      sv_sum;
  logic [30:0]      h_eff;
  logic [2:0][97:0] num;
  logic [DIV_W-1:0] den_w;

  always_comb begin
    s2_sum = '0;
    sv_sum = '0;
    for (int j = 0; j < 3; j++) begin
      dd[j] = {pos[j][31], pos[j]} - {center[j][31], center[j]};
      vv[j] = {vel[j][31], vel[j]};
      s2_sum = s2_sum + {2'b00, sq2_r[j]};
      if (pn2_r[j]) begin
        sv_sum = sv_sum - {3'b000, pr2_r[j]};
      end else begin
        sv_sum = sv_sum + {3'b000, pr2_r[j]};
      end
      num[j] = {34'd0, nlo5_r[j]} + {nhi5_r[j], 32'd0};
    end
    h_eff = (hubble == '0) ? 31'd1 : hubble;
    den_w = {{(DIV_W-DEN_W){1'b0}}, den5_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; bus_r.valid <= 1'b0;
    end else begin
      v1_r <= in_take; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r; v5_r <= v4_r; bus_r.valid <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pos1_r[j]  <= pos[j];
      dneg1_r[j] <= dd[j][32];
      dm1_r[j]   <= dd[j][32] ? 32'(-dd[j]) : dd[j][31:0];
      vneg1_r[j] <= vv[j][32];
      vm1_r[j]   <= vv[j][32] ? 32'(-vv[j]) : vv[j][31:0];

      pos2_r[j]  <= pos1_r[j];
      dm2_r[j]   <= dm1_r[j];
      dneg2_r[j] <= dneg1_r[j];
      pn2_r[j]   <= dneg1_r[j] ^ vneg1_r[j];
      sq2_r[j]   <= 64'(dm1_r[j]) * 64'(dm1_r[j]);
      pr2_r[j]   <= 64'(dm1_r[j]) * 64'(vm1_r[j]);

      pos3_r[j]  <= pos2_r[j];
      dm3_r[j]   <= dm2_r[j];
      dneg3_r[j] <= dneg2_r[j];

      pos4_r[j]  <= pos3_r[j];
      dm4_r[j]   <= dm3_r[j];
      dneg4_r[j] <= dneg3_r[j];

      pos5_r[j]  <= pos4_r[j];
      dneg5_r[j] <= dneg4_r[j];
      nlo5_r[j]  <= 64'(svm4_r[31:0]) * 64'(dm4_r[j]);
      nhi5_r[j]  <= 66'(svm4_r[65:32]) * 66'(dm4_r[j]);

      bus_r.rem[j] <= DIV_W'({{(DIV_W-98){1'b0}}, num[j]} << FRAC_BITS);
      bus_r.quo[j] <= '0;
      bus_r.ovf[j] <= DIV_W'({{(DIV_W-98){1'b0}}, num[j]} << FRAC_BITS)
                      >= (den_w << QW);
    end
    s2_3_r <= s2_sum;
    sv3_r  <= sv_sum;

    svneg4_r <= sv3_r[66];
    svm4_r   <= sv3_r[66] ? 66'(-sv3_r) : sv3_r[65:0];
    zero4_r  <= (s2_3_r == '0);
    dlo4_r   <= 63'(s2_3_r[31:0]) * 63'(h_eff);
    dhi4_r   <= 65'(s2_3_r[65:32]) * 65'(h_eff);

    svneg5_r <= svneg4_r;
    zero5_r  <= zero4_r;
    den5_r   <= {34'd0, dlo4_r} + {dhi4_r, 32'd0};

    bus_r.side.pos   <= pos5_r;
    bus_r.side.dneg  <= dneg5_r;
    bus_r.side.svneg <= svneg5_r;
    bus_r.side.zero  <= zero5_r;
    bus_r.den        <= den_w;
  end

  assign bus = bus_r;

endmodule

### rtl/rsp_div_step.sv
// ----------------------------------------------------------------------------
// rsp_div_step
// One restoring-division stage: resolves one quotient bit on all three axes.
// ----------------------------------------------------------------------------
module rsp_div_step import rsp_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  div_bus_t bus_in,
  output div_bus_t bus_out
);

  div_bus_t         bus_r;
  logic [DIV_W-1:0] dsh;

  assign dsh = bus_in.den << SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else begin
      bus_r.valid <= bus_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    bus_r.side <= bus_in.side;
    bus_r.den  <= bus_in.den;
    bus_r.ovf  <= bus_in.ovf;
    for (int j = 0; j < 3; j++) begin
      if (bus_in.rem[j] >= dsh) begin
        bus_r.rem[j] <= bus_in.rem[j] - dsh;
        bus_r.quo[j] <= bus_in.quo[j] | (QW'(1) << SHIFT);
      end else begin
        bus_r.rem[j] <= bus_in.rem[j];
        bus_r.quo[j] <= bus_in.quo[j];
      end
    end
  end

  assign bus_out = bus_r;

endmodule

### rtl/rsp_back.sv
// ----------------------------------------------------------------------------
// rsp_back
// Output stage: apply the signed offset, saturate, and form status.
// ----------------------------------------------------------------------------
module rsp_back import rsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_bus_t         bus_in,
  output logic             out_valid,
  output logic [2:0][31:0] out_new,
  output logic [1:0]       out_status
);

  localparam logic [QW-1:0] QMAX = QW'(1) << (QW-1);

  logic             valid_r;
  logic [2:0][31:0] new_r;
  logic [1:0]       status_r;
  logic [2:0][31:0] res;
  logic [2:0][35:0] sum;
  logic [2:0]       neg;
  logic             sat;

  always_comb begin
    sat = 1'b0;
    for (int j = 0; j < 3; j++) begin
      neg[j] = bus_in.side.svneg ^ bus_in.side.dneg[j];
      if (neg[j]) begin
        sum[j] = {{4{bus_in.side.pos[j][31]}}, bus_in.side.pos[j]}
                 - {1'b0, bus_in.quo[j]};
      end else begin
        sum[j] = {{4{bus_in.side.pos[j][31]}}, bus_in.side.pos[j]}
                 + {1'b0, bus_in.quo[j]};
      end
      if (bus_in.ovf[j] || bus_in.quo[j] > QMAX) begin
        res[j] = neg[j] ? 32'h8000_0000 : 32'h7fff_ffff;
        sat = 1'b1;
      end else if ($signed(sum[j]) > $signed(36'sh0_7fff_ffff)) begin
        res[j] = 32'h7fff_ffff;
        sat = 1'b1;
      end else if ($signed(sum[j]) < -$signed(36'sh0_8000_0000)) begin
        res[j] = 32'h8000_0000;
        sat = 1'b1;
      end else begin
        res[j] = sum[j][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= bus_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bus_in.side.zero) begin
      new_r    <= bus_in.side.pos;
      status_r <= ST_CENTER;
    end else begin
      new_r    <= res;
      status_r <= sat ? ST_SAT : ST_OK;
    end
  end

  assign out_valid  = valid_r;
  assign out_new    = new_r;
  assign out_status = status_r;

endmodule

### rtl/redshift_space_position_map_core.sv
// Pipeline from start to the out_valid strobe: 6 front stages,
// one restoring-division stage per quotient bit (35), one output stage.
// Throughput: one item per cycle; busy is always low and results never wait.
// Reset (rst_n low, synchronous) clears all valid bits, sets H to 1.0 and the
// observer centre to zero.
// ----------------------------------------------------------------------------
// redshift_space_position_map_core
// Maps particle positions into redshift space along the line of sight.
// ----------------------------------------------------------------------------
module redshift_space_position_map_core import rsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_vel_x,
  input  logic [31:0] in_vel_y,
  input  logic [31:0] in_vel_z,
  output logic        out_valid,
  output logic [31:0] out_new_x,
  output logic [31:0] out_new_y,
  output logic [31:0] out_new_z,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [30:0]      hubble_r;
  logic [2:0][31:0] center_r;
  logic [2:0][31:0] new_w;
  div_bus_t         bus [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hubble_r <= 31'(64'd1 << FRAC_BITS);
      center_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HUBBLE: hubble_r    <= cfg_wdata[30:0];
        REG_CX:     center_r[0] <= cfg_wdata;
        REG_CY:     center_r[1] <= cfg_wdata;
        REG_CZ:     center_r[2] <= cfg_wdata;
        default:    hubble_r    <= hubble_r;
      endcase
    end
  end

  assign busy = 1'b0;

  rsp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_take(start),
    .pos    ({in_pos_z, in_pos_y, in_pos_x}),
    .vel    ({in_vel_z, in_vel_y, in_vel_x}),
    .hubble (hubble_r),
    .center (center_r),
    .bus    (bus[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_div
    rsp_div_step #(.SHIFT(QW-1-k)) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .bus_in (bus[k]),
      .bus_out(bus[k+1])
    );
  end

  rsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .bus_in    (bus[QW]),
    .out_valid (out_valid),
    .out_new   (new_w),
    .out_status(out_status)
  );

  assign out_new_x = new_w[0];
  assign out_new_y = new_w[1];
  assign out_new_z = new_w[2];

endmodule
